// ===== rtl/poti_pkg.sv =====
// Shared types and constants of the pair overlap time integrator.
// Used by poti_span, the top and the checker; depends on nothing else.
package poti_pkg;

  // Width of the overlap integral; the span adder is one bit wider.
  localparam int AccW = 64;

  // Configuration register indexes.
  localparam logic CfgBeta  = 1'b0;
  localparam logic CfgTotal = 1'b1;

  // Register reset values.
  localparam logic [31:0] BetaReset  = 32'hFFFF_FFFF;
  localparam logic [6:0]  TotalReset = 7'd2;

  typedef enum logic [1:0] {
    CMD_SEED   = 2'd0,
    CMD_HOP    = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_BAD_PART  = 3'd1,
    STAT_MISMATCH  = 3'd2,
    STAT_EMPTY     = 3'd3,
    STAT_BACKWARDS = 3'd4,
    STAT_OVERFLOW  = 3'd5,
    STAT_COUNT     = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_WRITE = 4'b0100,
    S_CLEAR = 4'b1000
  } state_e;

  // Sum of the integral and one product, with the carry out of the top bit.
  typedef struct packed {
    logic [AccW-1:0] sum;
    logic            carry;
  } span_t;

endpackage

// ===== rtl/poti_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// A read of the address being written returns the old contents. No dependencies.
module poti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/poti_span.sv =====
// Span unit: registers delta times pair count, then adds it to the integral.
// Depends on poti_pkg for the integral width and the result struct.
module poti_span #(
  parameter int TW = 32,
  parameter int PW = 11
) (
  input  logic                       clk_i,
  input  logic                       load_i,
  input  logic [TW-1:0]              delta_i,
  input  logic [PW-1:0]              pairs_i,
  input  logic [poti_pkg::AccW-1:0]  acc_i,
  output poti_pkg::span_t            res_o
);

  localparam int SumW = poti_pkg::AccW + 1;

  logic [TW+PW-1:0] prod_q;
  logic [SumW-1:0]  sum;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= delta_i * pairs_i;
    end
  end

  assign sum = {1'b0, acc_i} + SumW'(prod_q);

  assign res_o.sum   = sum[poti_pkg::AccW-1:0];
  assign res_o.carry = sum[SumW-1];

endmodule

// ===== rtl/pair_overlap_time_integrator.sv =====
// Pair overlap time integrator.
//
// Input channel (in_valid_i/in_ready_o) takes one command beat: seed, hop or
// finish. Output channel (out_valid_o/out_ready_i) returns one result beat per
// command: the overlap integral, the current pair count, a status code and a
// flag that marks the end of a sweep. Configuration beats (beta_time at index
// 0, particle_total at index 1) are always taken, and must arrive while idle.
//
// Particle sites and site occupancies live in two RAMs with registered reads.
// A seed reads the occupancy entry, then updates it; a hop reads the departure
// entry, then writes the departure and reads the arrival, then writes the
// arrival. Results enter the output register from S_EXEC (seed, finish, unused
// code, failed hop) or from S_WRITE (hop). A finish is followed by a clearing
// pass over every entry of the occupancy RAM; the same pass runs after reset,
// and no command is taken during it.
// The output register holds a result while the receiver stalls; the next
// command is taken meanwhile and waits at its last step until the register
// frees up.
// Depends on poti_pkg, poti_ram and poti_span.
module pair_overlap_time_integrator #(
  parameter int MAX_PARTICLES = 64,
  parameter int SITE_COUNT    = 1024,
  parameter int TIME_BITS     = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [5:0]  particle_i,
  input  logic [9:0]  from_site_i,
  input  logic [9:0]  to_site_i,
  input  logic [31:0] event_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] overlap_total_o,
  output logic [10:0] pairs_now_o,
  output logic [2:0]  status_o,
  output logic        done_res_o
);

  localparam int PIW      = $clog2(MAX_PARTICLES);
  localparam int SW       = $clog2(SITE_COUNT);
  localparam int OW       = $clog2(MAX_PARTICLES + 1);
  localparam int MaxPairs = MAX_PARTICLES * (MAX_PARTICLES - 1) / 2;
  localparam int PW       = $clog2(MaxPairs + 1);
  localparam int TW       = TIME_BITS;
  localparam int AW       = poti_pkg::AccW;

  poti_pkg::state_e  state_q, state_d;
  poti_pkg::status_e err_q, err_d;
  poti_pkg::status_e seed_st, hop_st, fin_st, res_stat;
  poti_pkg::status_e ostat_q, ostat_d;

  logic [1:0]    cmd_q;
  logic [5:0]    p_q;
  logic [9:0]    from_q, to_q;
  logic [TW-1:0] t_q;

  logic [31:0]   beta_q;
  logic [6:0]    ptotal_q;

  logic [PW-1:0] pair_q, pair_d;
  logic [TW-1:0] last_q, last_d;
  logic [AW-1:0] acc_q, acc_d;
  logic [OW-1:0] seeded_q, seeded_d;
  logic [OW-1:0] dec_q, dec_d;
  logic [SW-1:0] clr_q, clr_d;

  logic          out_valid_q, out_valid_d;
  logic [AW-1:0] total_q, total_d;
  logic [10:0]   opairs_q, opairs_d;
  logic          done_q, done_d;

  logic          occ_we, occ_re;
  logic [SW-1:0] occ_waddr, occ_raddr;
  logic [OW-1:0] occ_wdata, occ_rdata;
  logic          ps_we, ps_re;
  logic [PIW-1:0] ps_waddr, ps_raddr;
  logic [SW-1:0] ps_wdata, ps_rdata;

  logic          in_fire, out_free;
  logic          from_in_range, to_in_range, p_ok, site_match, occ_zero;
  logic          t_back, beta_back, seed_full, count_bad;
  logic [TW-1:0] beta_t, delta;
  logic [OW-1:0] eff;
  logic [PW-1:0] seed_pairs, hop_pairs;
  logic          res_valid, res_done;
  logic [AW-1:0] res_total;
  logic [PW-1:0] res_pairs;

  poti_pkg::span_t span;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == poti_pkg::S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  assign beta_t = TW'(beta_q);
  assign delta  = ((command_i == poti_pkg::CMD_FINISH) ? beta_t : TW'(event_time_i)) - last_q;

  poti_span #(
    .TW (TW),
    .PW (PW)
  ) u_span (
    .clk_i   (clk_i),
    .load_i  (in_fire),
    .delta_i (delta),
    .pairs_i (pair_q),
    .acc_i   (acc_q),
    .res_o   (span)
  );

  poti_ram #(
    .WIDTH (OW),
    .DEPTH (SITE_COUNT)
  ) u_occ_ram (
    .clk_i   (clk_i),
    .we_i    (occ_we),
    .waddr_i (occ_waddr),
    .wdata_i (occ_wdata),
    .re_i    (occ_re),
    .raddr_i (occ_raddr),
    .rdata_o (occ_rdata)
  );

  poti_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_PARTICLES)
  ) u_site_ram (
    .clk_i   (clk_i),
    .we_i    (ps_we),
    .waddr_i (ps_waddr),
    .wdata_i (ps_wdata),
    .re_i    (ps_re),
    .raddr_i (ps_raddr),
    .rdata_o (ps_rdata)
  );

  // Checks on the latched command and the entries read back.
  assign from_in_range = 17'(from_q) < 17'(SITE_COUNT);
  assign to_in_range   = 17'(to_q) < 17'(SITE_COUNT);
  assign p_ok          = (9'(p_q) < 9'(seeded_q)) && (9'(p_q) < 9'(MAX_PARTICLES));
  assign site_match    = 16'(ps_rdata) == 16'(from_q);
  assign occ_zero      = (occ_rdata == '0);
  assign t_back        = t_q < last_q;
  assign beta_back     = beta_t < last_q;
  assign seed_full     = seeded_q >= OW'(MAX_PARTICLES);
  assign count_bad     = 9'(seeded_q) != 9'(ptotal_q);

  always_comb begin
    if (seed_full) begin
      seed_st = poti_pkg::STAT_COUNT;
    end else if (!from_in_range) begin
      seed_st = poti_pkg::STAT_EMPTY;
    end else begin
      seed_st = poti_pkg::STAT_OK;
    end

    if (!p_ok) begin
      hop_st = poti_pkg::STAT_BAD_PART;
    end else if (!site_match) begin
      hop_st = poti_pkg::STAT_MISMATCH;
    end else if (!from_in_range || !to_in_range || occ_zero) begin
      hop_st = poti_pkg::STAT_EMPTY;
    end else if (t_back) begin
      hop_st = poti_pkg::STAT_BACKWARDS;
    end else if (span.carry) begin
      hop_st = poti_pkg::STAT_OVERFLOW;
    end else begin
      hop_st = poti_pkg::STAT_OK;
    end

    if (err_q != poti_pkg::STAT_OK) begin
      fin_st = err_q;
    end else if (beta_back) begin
      fin_st = poti_pkg::STAT_BACKWARDS;
    end else if (span.carry) begin
      fin_st = poti_pkg::STAT_OVERFLOW;
    end else if (count_bad) begin
      fin_st = poti_pkg::STAT_COUNT;
    end else begin
      fin_st = poti_pkg::STAT_OK;
    end
  end

  // When departure and arrival coincide, the arrival read saw the old count.
  assign eff        = (to_q == from_q) ? dec_q : occ_rdata;
  assign seed_pairs = pair_q + PW'(occ_rdata);
  assign hop_pairs  = pair_q - PW'(dec_q) + PW'(eff);

  always_comb begin
    state_d   = state_q;
    err_d     = err_q;
    pair_d    = pair_q;
    last_d    = last_q;
    acc_d     = acc_q;
    seeded_d  = seeded_q;
    dec_d     = dec_q;
    clr_d     = clr_q;

    occ_we    = 1'b0;
    occ_waddr = SW'(from_q);
    occ_wdata = occ_rdata + OW'(1);
    occ_re    = in_fire;
    occ_raddr = SW'(from_site_i);
    ps_we     = 1'b0;
    ps_waddr  = seeded_q[PIW-1:0];
    ps_wdata  = SW'(from_q);
    ps_re     = in_fire;
    ps_raddr  = PIW'(particle_i);

    res_valid = 1'b0;
    res_total = acc_q;
    res_pairs = pair_q;
    res_stat  = poti_pkg::STAT_OK;
    res_done  = 1'b0;

    case (state_q)
      poti_pkg::S_IDLE: begin
        if (in_fire) begin
          state_d = poti_pkg::S_EXEC;
        end
      end

      poti_pkg::S_EXEC: begin
        case (cmd_q)
          poti_pkg::CMD_SEED: begin
            res_valid = 1'b1;
            if (err_q != poti_pkg::STAT_OK) begin
              res_stat = err_q;
            end else begin
              res_stat = seed_st;
              if (seed_st == poti_pkg::STAT_OK) begin
                res_pairs = seed_pairs;
                if (out_free) begin
                  occ_we   = 1'b1;
                  ps_we    = 1'b1;
                  pair_d   = seed_pairs;
                  seeded_d = seeded_q + OW'(1);
                end
              end else if (out_free) begin
                err_d = seed_st;
              end
            end
            if (out_free) begin
              state_d = poti_pkg::S_IDLE;
            end
          end

          poti_pkg::CMD_HOP: begin
            if (err_q != poti_pkg::STAT_OK || hop_st != poti_pkg::STAT_OK) begin
              res_valid = 1'b1;
              res_stat  = (err_q != poti_pkg::STAT_OK) ? err_q : hop_st;
              if (out_free) begin
                err_d   = res_stat;
                state_d = poti_pkg::S_IDLE;
              end
            end else begin
              // Leave the departure site and fetch the arrival count.
              occ_we    = 1'b1;
              occ_wdata = occ_rdata - OW'(1);
              occ_re    = 1'b1;
              occ_raddr = SW'(to_q);
              dec_d     = occ_rdata - OW'(1);
              state_d   = poti_pkg::S_WRITE;
            end
          end

          poti_pkg::CMD_FINISH: begin
            res_valid = 1'b1;
            res_done  = 1'b1;
            res_stat  = fin_st;
            if (err_q == poti_pkg::STAT_OK && !beta_back && !span.carry) begin
              res_total = span.sum;
            end
            if (out_free) begin
              pair_d   = '0;
              last_d   = '0;
              acc_d    = '0;
              seeded_d = '0;
              err_d    = poti_pkg::STAT_OK;
              clr_d    = '0;
              state_d  = poti_pkg::S_CLEAR;
            end
          end

          default: begin
            res_valid = 1'b1;
            if (out_free) begin
              state_d = poti_pkg::S_IDLE;
            end
          end
        endcase
      end

      poti_pkg::S_WRITE: begin
        res_valid = 1'b1;
        res_total = span.sum;
        res_pairs = hop_pairs;
        occ_waddr = SW'(to_q);
        occ_wdata = eff + OW'(1);
        ps_waddr  = PIW'(p_q);
        ps_wdata  = SW'(to_q);
        if (out_free) begin
          occ_we  = 1'b1;
          ps_we   = 1'b1;
          pair_d  = hop_pairs;
          acc_d   = span.sum;
          last_d  = t_q;
          state_d = poti_pkg::S_IDLE;
        end
      end

      poti_pkg::S_CLEAR: begin
        occ_we    = 1'b1;
        occ_waddr = clr_q;
        occ_wdata = '0;
        clr_d     = clr_q + SW'(1);
        if (clr_q == SW'(SITE_COUNT - 1)) begin
          state_d = poti_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = poti_pkg::S_CLEAR;
        clr_d   = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    total_d     = total_q;
    opairs_d    = opairs_q;
    ostat_d     = ostat_q;
    done_d      = done_q;
    if (res_valid && out_free) begin
      out_valid_d = 1'b1;
      total_d     = res_total;
      opairs_d    = 11'(res_pairs);
      ostat_d     = res_stat;
      done_d      = res_done;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= poti_pkg::S_CLEAR;
      err_q       <= poti_pkg::STAT_OK;
      pair_q      <= '0;
      last_q      <= '0;
      acc_q       <= '0;
      seeded_q    <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      beta_q      <= poti_pkg::BetaReset;
      ptotal_q    <= poti_pkg::TotalReset;
    end else begin
      state_q     <= state_d;
      err_q       <= err_d;
      pair_q      <= pair_d;
      last_q      <= last_d;
      acc_q       <= acc_d;
      seeded_q    <= seeded_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          poti_pkg::CfgBeta:  beta_q   <= cfg_data_i;
          poti_pkg::CfgTotal: ptotal_q <= cfg_data_i[6:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= command_i;
      p_q    <= particle_i;
      from_q <= from_site_i;
      to_q   <= to_site_i;
      t_q    <= TW'(event_time_i);
    end
    dec_q    <= dec_d;
    total_q  <= total_d;
    opairs_q <= opairs_d;
    ostat_q  <= ostat_d;
    done_q   <= done_d;
  end

  assign out_valid_o     = out_valid_q;
  assign overlap_total_o = total_q;
  assign pairs_now_o     = opairs_q;
  assign status_o        = ostat_q;
  assign done_res_o      = done_q;

endmodule

// ===== rtl/poti_checker.sv =====
// Port-level checker for the pair overlap time integrator, bound to the top.
// Depends on poti_pkg for the status codes.
module poti_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] overlap_total_o,
  input logic [10:0] pairs_now_o,
  input logic [2:0]  status_o,
  input logic        done_res_o
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(overlap_total_o)
      && $stable(pairs_now_o) && $stable(status_o) && $stable(done_res_o))
    else $error("result beat changed while stalled");

  // One command is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second command taken while one is in progress");

  // A fresh finish result is followed by the clearing pass.
  a_clear_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && done_res_o |-> !in_ready_o)
    else $error("command taken before the store was cleared");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= poti_pkg::STAT_COUNT)
    else $error("undefined status code");

endmodule

bind pair_overlap_time_integrator poti_checker u_poti_checker (.*);
